// File: rtl/swsr_pkg.sv
// Package for the sliding window slot reassigner.
// Holds the shared constants, command and memory request types and the back end state type.
// No dependencies.
package swsr_pkg;

   // Window and coordinate geometry.
   localparam int WIN_SIDE    = 4;
   localparam int CHUNK_SHIFT = 5;
   localparam int SLOT_COUNT  = WIN_SIDE * WIN_SIDE * WIN_SIDE;
   localparam int SLOT_W      = $clog2(SLOT_COUNT);
   localparam int CNT_W       = SLOT_W + 1;
   localparam int OFF_W       = $clog2(WIN_SIDE);
   localparam int HALF        = WIN_SIDE / 2;
   localparam int CAM_W       = 24;
   localparam int COORD_W     = 20;

   // Command queue between the front and the back end.
   localparam int CMD_DEPTH   = 2;
   localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);

   // One chunk coordinate, x in the low bits, as it is kept in the slot memory.
   typedef struct packed {
      logic [COORD_W-1:0] z;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } coord_type;

   localparam int COORD_BITS = $bits(coord_type);

   // Classified camera update: fill the table or reassign slots against the new window.
   typedef struct packed {
      logic      fill;
      coord_type base;
   } cmd_type;

   // Access request to the slot memory.
   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      coord_type         wr_data;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
   } mem_req_type;

   // Payload of one result.
   typedef struct packed {
      logic [SLOT_W-1:0] slot_index;
      coord_type         coord;
      logic              assigned;
      logic              last;
   } rsp_type;

   // Window offset digits along x, y and z.
   typedef struct packed {
      logic [OFF_W-1:0] i;
      logic [OFF_W-1:0] j;
      logic [OFF_W-1:0] k;
   } digits_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FILL,
      BK_SCAN,
      BK_ASSIGN,
      BK_NOCHG
   } back_state_type;

endpackage

// File: rtl/swsr_ram.sv
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module swsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/swsr_front.sv
// Front end: accepts camera positions, computes the window base and classifies each update.
// Depends on swsr_pkg.
module swsr_front
   import swsr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [CAM_W-1:0] req_cam_x,
   input  logic signed [CAM_W-1:0] req_cam_y,
   input  logic signed [CAM_W-1:0] req_cam_z,
   input  logic                    queue_full,
   output logic                    push,
   output cmd_type                 push_cmd
);

   logic                    filled_ff;
   logic                    filled_in;
   logic signed [CAM_W-1:0] shift_x;
   logic signed [CAM_W-1:0] shift_y;
   logic signed [CAM_W-1:0] shift_z;

   // Accept whenever the command queue has room.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // The camera chunk is the floored quotient, kept modulo the coordinate width.
   assign shift_x = req_cam_x >>> CHUNK_SHIFT;
   assign shift_y = req_cam_y >>> CHUNK_SHIFT;
   assign shift_z = req_cam_z >>> CHUNK_SHIFT;

   // The window base is the camera chunk minus half the window side.
   always_comb begin
      push_cmd.fill   = !filled_ff;
      push_cmd.base.x = shift_x[COORD_W-1:0] - COORD_W'(HALF);
      push_cmd.base.y = shift_y[COORD_W-1:0] - COORD_W'(HALF);
      push_cmd.base.z = shift_z[COORD_W-1:0] - COORD_W'(HALF);
      filled_in       = filled_ff || push;
   end

   // Only the first update after reset fills the table.
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= 1'b0;
      end else begin
         filled_ff <= filled_in;
      end
   end

endmodule

// File: rtl/swsr_cmd_fifo.sv
// Short command queue that decouples the front end from the back end.
// Depends on swsr_pkg.
module swsr_cmd_fifo
   import swsr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    full,
   output logic    empty
);

   cmd_type              entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff;
   logic [CMD_PTR_W-1:0] wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff;
   logic [CMD_PTR_W-1:0] rd_ptr_in;
   logic [CMD_PTR_W:0]   count_ff;
   logic [CMD_PTR_W:0]   count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == (CMD_PTR_W+1)'(CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/swsr_back.sv
// Back end: walks the slot memory against the window and emits one result per written slot,
// else one unassigned result. Depends on swsr_pkg; drives slot memory via a request struct.
module swsr_back
   import swsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        queue_empty,
   input  cmd_type     queue_cmd,
   output logic        queue_pop,
   output mem_req_type mem_req,
   input  coord_type   mem_rd_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp
);

   back_state_type        state_ff;
   back_state_type        state_in;
   coord_type             base_ff;
   coord_type             base_in;
   logic [SLOT_W-1:0]     slot_ff;
   logic [SLOT_W-1:0]     slot_in;
   logic [SLOT_W-1:0]     pos_ff;
   logic [SLOT_W-1:0]     pos_in;
   digits_type            digits_ff;
   digits_type            digits_in;
   logic [CNT_W-1:0]      rd_cnt_ff;
   logic [CNT_W-1:0]      rd_cnt_in;
   logic                  chk_valid_ff;
   logic                  chk_valid_in;
   logic [SLOT_W-1:0]     chk_idx_ff;
   logic [SLOT_W-1:0]     chk_idx_in;
   logic [SLOT_COUNT-1:0] claimed_ff;
   logic [SLOT_COUNT-1:0] claimed_in;
   logic [SLOT_COUNT-1:0] freed_ff;
   logic [SLOT_COUNT-1:0] freed_in;
   logic [CNT_W-1:0]      free_cnt_ff;
   logic [CNT_W-1:0]      free_cnt_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   logic                  out_free;
   logic [COORD_W-1:0]    off_x;
   logic [COORD_W-1:0]    off_y;
   logic [COORD_W-1:0]    off_z;
   logic                  in_window;
   logic [SLOT_W-1:0]     hit_pos;
   coord_type             win_coord;
   digits_type            digits_next;

   // Chunk coordinate of the current window position.
   always_comb begin
      win_coord.x = base_ff.x + COORD_W'(digits_ff.i);
      win_coord.y = base_ff.y + COORD_W'(digits_ff.j);
      win_coord.z = base_ff.z + COORD_W'(digits_ff.k);
   end

   // Step the window position digits in linear order, z fastest.
   always_comb begin
      digits_next = digits_ff;
      if (digits_ff.k == OFF_W'(WIN_SIDE-1)) begin
         digits_next.k = '0;
         if (digits_ff.j == OFF_W'(WIN_SIDE-1)) begin
            digits_next.j = '0;
            digits_next.i = digits_ff.i + 1'b1;
         end else begin
            digits_next.j = digits_ff.j + 1'b1;
         end
      end else begin
         digits_next.k = digits_ff.k + 1'b1;
      end
   end

   // Window membership of the slot read last cycle, and the position it claims.
   always_comb begin
      off_x     = mem_rd_data.x - base_ff.x;
      off_y     = mem_rd_data.y - base_ff.y;
      off_z     = mem_rd_data.z - base_ff.z;
      in_window = (off_x < COORD_W'(WIN_SIDE)) && (off_y < COORD_W'(WIN_SIDE)) &&
                  (off_z < COORD_W'(WIN_SIDE));
      hit_pos   = SLOT_W'(off_x[OFF_W-1:0]) * SLOT_W'(WIN_SIDE * WIN_SIDE) +
                  SLOT_W'(off_y[OFF_W-1:0]) * SLOT_W'(WIN_SIDE) +
                  SLOT_W'(off_z[OFF_W-1:0]);
   end

   // The output register may take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and outputs.
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      slot_in      = slot_ff;
      pos_in       = pos_ff;
      digits_in    = digits_ff;
      rd_cnt_in    = rd_cnt_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      claimed_in   = claimed_ff;
      freed_in     = freed_ff;
      free_cnt_in  = free_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      queue_pop    = 1'b0;
      mem_req      = '0;

      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               queue_pop   = 1'b1;
               base_in     = queue_cmd.base;
               slot_in     = '0;
               digits_in   = '0;
               claimed_in  = '0;
               freed_in    = '0;
               free_cnt_in = '0;
               rd_cnt_in   = '0;
               state_in    = queue_cmd.fill ? BK_FILL : BK_SCAN;
            end
         end

         // Every slot takes the window position of the same index.
         BK_FILL: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.slot_index = slot_ff;
               rsp_in.coord      = win_coord;
               rsp_in.assigned   = 1'b1;
               rsp_in.last       = (slot_ff == SLOT_W'(SLOT_COUNT-1));
               mem_req.wr_en     = 1'b1;
               mem_req.wr_addr   = slot_ff;
               mem_req.wr_data   = win_coord;
               slot_in           = slot_ff + 1'b1;
               digits_in         = digits_next;
               if (slot_ff == SLOT_W'(SLOT_COUNT-1)) begin
                  state_in = BK_IDLE;
               end
            end
         end

         // Read each slot, then mark its window position claimed or the slot freed.
         BK_SCAN: begin
            if (rd_cnt_ff < CNT_W'(SLOT_COUNT)) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_cnt_ff[SLOT_W-1:0];
               rd_cnt_in       = rd_cnt_ff + 1'b1;
               chk_valid_in    = 1'b1;
               chk_idx_in      = rd_cnt_ff[SLOT_W-1:0];
            end
            if (chk_valid_ff) begin
               if (in_window) begin
                  claimed_in[hit_pos] = 1'b1;
               end else begin
                  freed_in[chk_idx_ff] = 1'b1;
                  free_cnt_in          = free_cnt_ff + 1'b1;
               end
               if (chk_idx_ff == SLOT_W'(SLOT_COUNT-1)) begin
                  slot_in   = '0;
                  pos_in    = '0;
                  digits_in = '0;
                  state_in  = (free_cnt_in == '0) ? BK_NOCHG : BK_ASSIGN;
               end
            end
         end

         // Walk freed slots and unclaimed positions together, both ascending.
         BK_ASSIGN: begin
            if (!freed_ff[slot_ff]) begin
               slot_in = slot_ff + 1'b1;
            end else if (claimed_ff[pos_ff]) begin
               pos_in    = pos_ff + 1'b1;
               digits_in = digits_next;
            end else if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.slot_index = slot_ff;
               rsp_in.coord      = win_coord;
               rsp_in.assigned   = 1'b1;
               rsp_in.last       = (free_cnt_ff == CNT_W'(1));
               mem_req.wr_en     = 1'b1;
               mem_req.wr_addr   = slot_ff;
               mem_req.wr_data   = win_coord;
               slot_in           = slot_ff + 1'b1;
               pos_in            = pos_ff + 1'b1;
               digits_in         = digits_next;
               free_cnt_in       = free_cnt_ff - 1'b1;
               if (free_cnt_ff == CNT_W'(1)) begin
                  state_in = BK_IDLE;
               end
            end
         end

         // Nothing moved: a single unassigned result closes the update.
         BK_NOCHG: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.slot_index = '0;
               rsp_in.coord      = '0;
               rsp_in.assigned   = 1'b0;
               rsp_in.last       = 1'b1;
               state_in          = BK_IDLE;
            end
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // State register and control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and result payload.
   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      slot_ff     <= slot_in;
      pos_ff      <= pos_in;
      digits_ff   <= digits_in;
      rd_cnt_ff   <= rd_cnt_in;
      chk_idx_ff  <= chk_idx_in;
      claimed_ff  <= claimed_in;
      freed_ff    <= freed_in;
      free_cnt_ff <= free_cnt_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: rtl/sliding_window_slot_reassigner.sv
// Sliding window slot reassigner, top level: front end, command queue, back end, slot memory.
// First update after reset: 64 results, one per cycle while the output is not stalled.
// Later updates: a scan of the slot memory (one read port, one slot a cycle), then a walk of
// freed slots against unclaimed positions. Reset clears control state; the slot memory is not
// cleared, since the first update writes every slot before any read.
module sliding_window_slot_reassigner
   import swsr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [CAM_W-1:0]   req_cam_x,
   input  logic signed [CAM_W-1:0]   req_cam_y,
   input  logic signed [CAM_W-1:0]   req_cam_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SLOT_W-1:0]         rsp_slot_index,
   output logic signed [COORD_W-1:0] rsp_chunk_x,
   output logic signed [COORD_W-1:0] rsp_chunk_y,
   output logic signed [COORD_W-1:0] rsp_chunk_z,
   output logic                      rsp_assigned,
   output logic                      rsp_last
);

   logic        push;
   cmd_type     push_cmd;
   logic        queue_full;
   logic        queue_empty;
   logic        queue_pop;
   cmd_type     queue_cmd;
   mem_req_type mem_req;
   coord_type   mem_rd_data;
   rsp_type     rsp;

   // Classify camera updates.
   swsr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cam_x  (req_cam_x),
      .req_cam_y  (req_cam_y),
      .req_cam_z  (req_cam_z),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Decouple front from back.
   swsr_cmd_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (queue_pop),
      .pop_cmd  (queue_cmd),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // Slot reassignment.
   swsr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_cmd   (queue_cmd),
      .queue_pop   (queue_pop),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp)
   );

   // Slot coordinate table.
   swsr_ram #(
      .WIDTH (COORD_BITS),
      .DEPTH (SLOT_COUNT)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   // Result payload onto its ports.
   assign rsp_slot_index = rsp.slot_index;
   assign rsp_chunk_x    = rsp.coord.x;
   assign rsp_chunk_y    = rsp.coord.y;
   assign rsp_chunk_z    = rsp.coord.z;
   assign rsp_assigned   = rsp.assigned;
   assign rsp_last       = rsp.last;

endmodule

// File: rtl/swsr_checker.sv
// Port-level checker for the sliding window slot reassigner, bound to the top level.
// Depends on swsr_pkg.
module swsr_checker
   import swsr_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic signed [CAM_W-1:0]   req_cam_x,
   input logic signed [CAM_W-1:0]   req_cam_y,
   input logic signed [CAM_W-1:0]   req_cam_z,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [SLOT_W-1:0]         rsp_slot_index,
   input logic signed [COORD_W-1:0] rsp_chunk_x,
   input logic signed [COORD_W-1:0] rsp_chunk_y,
   input logic signed [COORD_W-1:0] rsp_chunk_z,
   input logic                      rsp_assigned,
   input logic                      rsp_last
);

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot_index) &&
         $stable(rsp_chunk_x) && $stable(rsp_chunk_y) && $stable(rsp_chunk_z) &&
         $stable(rsp_assigned) && $stable(rsp_last))
   else $error("stalled result changed");

   // The no-change result is alone, final and zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_assigned |-> rsp_last && (rsp_slot_index == '0) &&
         (rsp_chunk_x == '0) && (rsp_chunk_y == '0) && (rsp_chunk_z == '0))
   else $error("no-change result malformed");

   // Slots are written in ascending order, so the top slot always closes an update.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_assigned && (rsp_slot_index == SLOT_W'(SLOT_COUNT-1)) |-> rsp_last)
   else $error("top slot result not final");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
   else $error("result valid after reset");

endmodule

bind sliding_window_slot_reassigner swsr_checker u_swsr_checker (.*);

// File: sim/tb_sliding_window_slot_reassigner.sv
// Self-checking testbench for the sliding window slot reassigner.
// Depends on swsr_pkg and the sliding_window_slot_reassigner top level; a scoreboard class
// predicts the slot updates that each camera transaction causes.
module tb_sliding_window_slot_reassigner
   import swsr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // One expected or observed slot update, in port order.
   typedef struct packed {
      logic [SLOT_W-1:0]  slot_index;
      logic [COORD_W-1:0] chunk_x;
      logic [COORD_W-1:0] chunk_y;
      logic [COORD_W-1:0] chunk_z;
      logic               assigned;
      logic               last;
   } slot_update_type;

   // Tracks the slot table of the block and queues the slot updates it must emit.
   class slot_scoreboard;
      coord_type       slot_table[SLOT_COUNT];
      bit              table_filled;
      slot_update_type due_q[$];
      int              failures;

      function int pending();
         return due_q.size();
      endfunction

      // Floor division by the chunk size, kept modulo the coordinate width.
      function logic [COORD_W-1:0] chunk_of(logic signed [CAM_W-1:0] pos);
         logic signed [CAM_W-1:0] shifted;
         shifted = pos >>> CHUNK_SHIFT;
         return shifted[COORD_W-1:0];
      endfunction

      // Chunk coordinate held by window position p, counted from the low corner.
      function coord_type window_coord(coord_type corner, int p);
         coord_type c;
         c.x = corner.x + COORD_W'(p / (WIN_SIDE * WIN_SIDE));
         c.y = corner.y + COORD_W'((p / WIN_SIDE) % WIN_SIDE);
         c.z = corner.z + COORD_W'(p % WIN_SIDE);
         return c;
      endfunction

      function void log_failure(string what);
         failures++;
         if (failures <= 10) begin
            $display("[%0t] %s", $time, what);
         end
      endfunction

      // Works out the slot updates caused by one accepted camera transaction.
      function void note_camera(logic signed [CAM_W-1:0] cam_x, logic signed [CAM_W-1:0] cam_y,
                                logic signed [CAM_W-1:0] cam_z);
         coord_type          corner;
         coord_type          c;
         bit                 claimed[SLOT_COUNT];
         bit                 freed[SLOT_COUNT];
         logic [COORD_W-1:0] dx, dy, dz;
         slot_update_type    fresh[$];
         int                 next_free;
         corner.x = chunk_of(cam_x) - COORD_W'(HALF);
         corner.y = chunk_of(cam_y) - COORD_W'(HALF);
         corner.z = chunk_of(cam_z) - COORD_W'(HALF);
         if (!table_filled) begin
            // First camera after reset fills every slot in window order.
            for (int s = 0; s < SLOT_COUNT; s++) begin
               c = window_coord(corner, s);
               slot_table[s] = c;
               fresh.push_back('{SLOT_W'(s), c.x, c.y, c.z, 1'b1, 1'b0});
            end
            table_filled = 1'b1;
         end else begin
            // A slot stays when its offset from the low corner lies inside the cube.
            for (int p = 0; p < SLOT_COUNT; p++) begin
               claimed[p] = 1'b0;
            end
            for (int s = 0; s < SLOT_COUNT; s++) begin
               dx = slot_table[s].x - corner.x;
               dy = slot_table[s].y - corner.y;
               dz = slot_table[s].z - corner.z;
               freed[s] = !(dx < WIN_SIDE && dy < WIN_SIDE && dz < WIN_SIDE);
               if (!freed[s]) begin
                  claimed[dx * WIN_SIDE * WIN_SIDE + dy * WIN_SIDE + dz] = 1'b1;
               end
            end
            // Freed slots in ascending order take the lowest unclaimed positions.
            next_free = 0;
            for (int s = 0; s < SLOT_COUNT; s++) begin
               if (freed[s]) begin
                  while (next_free < SLOT_COUNT && claimed[next_free]) begin
                     next_free++;
                  end
                  if (next_free < SLOT_COUNT) begin
                     claimed[next_free] = 1'b1;
                     c = window_coord(corner, next_free);
                     slot_table[s] = c;
                     fresh.push_back('{SLOT_W'(s), c.x, c.y, c.z, 1'b1, 1'b0});
                  end
               end
            end
         end
         // A camera that moves no slot still gives one update with assigned clear.
         if (fresh.size() == 0) begin
            fresh.push_back('{'0, '0, '0, '0, 1'b0, 1'b0});
         end
         fresh[fresh.size() - 1].last = 1'b1;
         foreach (fresh[n]) begin
            due_q.push_back(fresh[n]);
         end
      endfunction

      // Compares one accepted slot update with the oldest expected one.
      function void check_update(slot_update_type got);
         slot_update_type want;
         if (due_q.size() == 0) begin
            log_failure($sformatf("unexpected update: slot %0d x %h y %h z %h asg %b last %b",
                                  got.slot_index, got.chunk_x, got.chunk_y, got.chunk_z,
                                  got.assigned, got.last));
            return;
         end
         want = due_q.pop_front();
         if (got !== want) begin
            log_failure($sformatf({"update mismatch: expected slot %0d x %h y %h z %h asg %b ",
                                   "last %b, got slot %0d x %h y %h z %h asg %b last %b"},
                                  want.slot_index, want.chunk_x, want.chunk_y, want.chunk_z,
                                  want.assigned, want.last, got.slot_index, got.chunk_x,
                                  got.chunk_y, got.chunk_z, got.assigned, got.last));
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [CAM_W-1:0]   req_cam_x = '0;
   logic signed [CAM_W-1:0]   req_cam_y = '0;
   logic signed [CAM_W-1:0]   req_cam_z = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [SLOT_W-1:0]         rsp_slot_index;
   logic signed [COORD_W-1:0] rsp_chunk_x;
   logic signed [COORD_W-1:0] rsp_chunk_y;
   logic signed [COORD_W-1:0] rsp_chunk_z;
   logic                      rsp_assigned;
   logic                      rsp_last;

   slot_scoreboard            sb;
   bit                        no_idle = 1'b0;
   logic signed [CAM_W-1:0]   cur_x = '0;
   logic signed [CAM_W-1:0]   cur_y = '0;
   logic signed [CAM_W-1:0]   cur_z = '0;

   sliding_window_slot_reassigner dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cam_x      (req_cam_x),
      .req_cam_y      (req_cam_y),
      .req_cam_z      (req_cam_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot_index (rsp_slot_index),
      .rsp_chunk_x    (rsp_chunk_x),
      .rsp_chunk_y    (rsp_chunk_y),
      .rsp_chunk_z    (rsp_chunk_z),
      .rsp_assigned   (rsp_assigned),
      .rsp_last       (rsp_last)
   );

   always #6 clock = ~clock;

   // The result side stalls now and then, except during the quiet stretch.
   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 6);
   end

   // Every accepted result transaction goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_update('{rsp_slot_index, rsp_chunk_x, rsp_chunk_y, rsp_chunk_z,
                           rsp_assigned, rsp_last});
      end
   end

   // Presents one camera transaction and holds it until the block takes it.
   task automatic send_camera(logic signed [CAM_W-1:0] x, logic signed [CAM_W-1:0] y,
                              logic signed [CAM_W-1:0] z);
      while (!no_idle && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cam_x <= x;
      req_cam_y <= y;
      req_cam_z <= z;
      do begin
         @(posedge clock);
      end while (req_stall);
      sb.note_camera(x, y, z);
      cur_x = x;
      cur_y = y;
      cur_z = z;
   endtask

   // Holds the sender back until every expected update has arrived.
   task automatic drain_updates();
      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // Moves a position by a number of chunks and picks a fresh offset inside the chunk.
   function automatic logic signed [CAM_W-1:0] shift_chunks(logic signed [CAM_W-1:0] pos,
                                                           int chunks);
      logic signed [CAM_W-1:0] ch;
      ch = (pos >>> CHUNK_SHIFT) + CAM_W'(chunks);
      return {ch[CAM_W-1-CHUNK_SHIFT:0], CHUNK_SHIFT'($urandom_range(2**CHUNK_SHIFT - 1))};
   endfunction

   // Main stimulus: directed camera positions, then a random walk with jumps.
   initial begin
      int kind;
      int axis;
      int hop;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Fill, no change, small moves along each axis, extremes and full jumps.
      send_camera(24'sd0, 24'sd0, 24'sd0);
      send_camera(24'sd0, 24'sd0, 24'sd0);
      send_camera(24'sd31, 24'sd31, 24'sd31);
      send_camera(24'sd32, 24'sd0, 24'sd0);
      send_camera(24'sd32, -24'sd1, 24'sd0);
      send_camera(24'sd32, -24'sd1, 24'sd64);
      send_camera(24'sh800000, 24'sh800000, 24'sh800000);
      send_camera(24'sh800020, 24'sh800000, 24'sh80001f);
      send_camera(24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
      send_camera(24'sh7fffdf, 24'sh7fffff, 24'sh7fff9f);
      send_camera(24'sh7fffff, 24'sh800000, 24'sd0);
      send_camera(-24'sd1, -24'sd1, -24'sd1);
      send_camera(24'sd0, 24'sd0, 24'sd0);
      send_camera(-24'sd128, 24'sd128, -24'sd128);
      send_camera(-24'sd96, 24'sd96, -24'sd96);
      send_camera(-24'sd96, 24'sd96, 24'sd0);
      send_camera(24'sh555555, 24'shaaaaaa, 24'sh5a5a5a);
      send_camera(24'shaaaaaa, 24'sh555555, 24'sha5a5a5);
      send_camera(24'shaaaaaa, 24'sh555555, 24'sha5a5a5);
      drain_updates();

      for (int n = 0; n < 291; n++) begin
         no_idle = (n >= 100 && n < 180);
         if (n == 200) begin
            drain_updates();
         end
         kind = $urandom_range(99);
         axis = $urandom_range(2);
         hop = $urandom_range(1) ? int'($urandom_range(6, 3)) : -int'($urandom_range(6, 3));
         if (kind < 50) begin
            // Small drift on every axis.
            send_camera(shift_chunks(cur_x, int'($urandom_range(4)) - 2),
                        shift_chunks(cur_y, int'($urandom_range(4)) - 2),
                        shift_chunks(cur_z, int'($urandom_range(4)) - 2));
         end else if (kind < 65) begin
            // One chunk along a single axis.
            hop = $urandom_range(1) ? 1 : -1;
            send_camera(shift_chunks(cur_x, axis == 0 ? hop : 0),
                        shift_chunks(cur_y, axis == 1 ? hop : 0),
                        shift_chunks(cur_z, axis == 2 ? hop : 0));
         end else if (kind < 75) begin
            // Movement inside the same chunk.
            send_camera(shift_chunks(cur_x, 0), shift_chunks(cur_y, 0),
                        shift_chunks(cur_z, 0));
         end else if (kind < 82) begin
            send_camera(cur_x, cur_y, cur_z);
         end else if (kind < 90) begin
            // Large hop along one axis that frees most or all slots.
            send_camera(shift_chunks(cur_x, axis == 0 ? hop : 0),
                        shift_chunks(cur_y, axis == 1 ? hop : 0),
                        shift_chunks(cur_z, axis == 2 ? hop : 0));
         end else begin
            send_camera(CAM_W'($urandom), CAM_W'($urandom), CAM_W'($urandom));
         end
      end
      no_idle = 1'b0;

      drain_updates();
      repeat (250) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog for a block that stops answering.
   initial begin
      #8000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
